// File: rtl/pav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pav_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 25;
  localparam int CNT_W      = $clog2(SQRT_STEPS);

  // percent per second in Q16.16 to a plain fraction: divide by 100 * 2^16 as a
  // shift by 18 and a multiply by 2^34 / 25 rounded up, exact below 2^30
  localparam logic [31:0] PCT_RECIP = 32'd687194768;

  localparam logic [2:0] REG_TARGET_X  = 3'd0;
  localparam logic [2:0] REG_TARGET_Y  = 3'd1;
  localparam logic [2:0] REG_ACCEL     = 3'd2;
  localparam logic [2:0] REG_REDUCTION = 3'd3;
  localparam logic [2:0] REG_REPEL     = 3'd4;
  localparam logic [2:0] REG_DELAY     = 3'd5;
  localparam logic [2:0] REG_RUN       = 3'd6;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [31:0] accel;
    logic [22:0]        reduction_pct;
    logic               repel;
    logic [23:0]        step_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } pav_req_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } pav_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    logic signed [31:0] r;
    if (v[42:31] == {12{v[42]}}) begin
      r = v[31:0];
    end else if (v[42]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/point_attraction_velocity_step.sv
// a tick beat, or a particle that is inactive or sits on the target, is in the
// output register in the cycle after acceptance; other particles go through the core
// one particle at a time, as s_tready stays low while the core is busy; the core uses a shared root and quotient
// subtractor (32 root digits, two 25-digit divides), eleven multiplier steps, three hand-offs
// reset: rst synchronous, clears flags, elapsed time, busy and output valid, and
// loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
module point_attraction_velocity_step (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [151:0] s_tdata,  // step_time, pos_x, pos_y, vel_x, vel_y
  input  wire logic         s_tuser,  // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,  // new_vel_x, new_vel_y
  output logic [1:0]        m_tuser,  // is_active, is_finished
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import pav_pkg::*;

  logic signed [15:0] target_x, target_y;
  logic signed [31:0] accel, run_length;
  logic [22:0]        reduction_pct;
  logic               repel;
  logic [30:0]        start_delay;

  logic [31:0] elapsed;
  logic        active, finished, busy;

  logic [23:0]        step_time;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;

  assign step_time = s_tdata[23:0];
  assign pos_x     = s_tdata[55:24];
  assign pos_y     = s_tdata[87:56];
  assign vel_x     = s_tdata[119:88];
  assign vel_y     = s_tdata[151:120];

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      REG_TARGET_X:  prdata = 32'(target_x);
      REG_TARGET_Y:  prdata = 32'(target_y);
      REG_ACCEL:     prdata = accel;
      REG_REDUCTION: prdata = {9'd0, reduction_pct};
      REG_REPEL:     prdata = {31'd0, repel};
      REG_DELAY:     prdata = {1'b0, start_delay};
      REG_RUN:       prdata = run_length;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x      <= '0;
      target_y      <= '0;
      accel         <= 32'sd2097152;
      reduction_pct <= '0;
      repel         <= 1'b0;
      start_delay   <= '0;
      run_length    <= -32'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_TARGET_X:  target_x      <= pwdata[15:0];
        REG_TARGET_Y:  target_y      <= pwdata[15:0];
        REG_ACCEL:     accel         <= pwdata;
        REG_REDUCTION: reduction_pct <= pwdata[22:0];
        REG_REPEL:     repel         <= pwdata[0];
        REG_DELAY:     start_delay   <= pwdata[30:0];
        REG_RUN:       run_length    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // tick update
  logic [32:0] thr, el_sum;
  logic        fin_hit, act_hit, on_target, s_acc, go;
  logic [31:0] el_sat;

  always_comb begin
    thr       = {1'b0, run_length} + {2'b0, start_delay};
    fin_hit   = ~run_length[31] && ({1'b0, elapsed} >= thr);
    act_hit   = elapsed > {1'b0, start_delay};
    el_sum    = {1'b0, elapsed} + {9'd0, step_time};
    el_sat    = el_sum[32] ? '1 : el_sum[31:0];
    on_target = pos_x == {target_x, 16'd0} && pos_y == {target_y, 16'd0};
    s_acc     = s_tvalid && s_tready;
    go        = s_acc && s_tuser && active && !on_target;
  end

  assign s_tready = !busy && (!m_tvalid || m_tready);

  pav_req_t req;
  pav_res_t res;
  logic     core_done;

  always_comb begin
    req.target_x      = target_x;
    req.target_y      = target_y;
    req.accel         = accel;
    req.reduction_pct = reduction_pct;
    req.repel         = repel;
    req.step_time     = step_time;
    req.pos_x         = pos_x;
    req.pos_y         = pos_y;
    req.vel_x         = vel_x;
    req.vel_y         = vel_y;
  end

  pav_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .req   (req),
    .done  (core_done),
    .res   (res)
  );

  logic active_next, finished_next;

  always_comb begin
    active_next   = active;
    finished_next = finished;
    if (s_acc && !s_tuser) begin
      if (fin_hit) begin
        finished_next = 1'b1;
      end else if (act_hit) begin
        active_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      active   <= 1'b0;
      finished <= 1'b0;
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      active   <= active_next;
      finished <= finished_next;
      if (s_acc && !s_tuser && !fin_hit) elapsed <= el_sat;
      if (go) begin
        busy <= 1'b1;
      end else if (core_done) begin
        busy <= 1'b0;
      end
      if ((s_acc && !go) || core_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      m_tdata <= {res.vel_y, res.vel_x};
      m_tuser <= {finished, active};
    end else if (s_acc && !go) begin
      m_tdata <= {vel_y, vel_x};
      m_tuser <= {finished_next, active_next};
    end
  end

endmodule
`default_nettype wire

// File: rtl/pav_core.sv
`timescale 1ns / 1ps
`default_nettype none
module pav_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pav_pkg::pav_req_t req,
  output logic                   done,
  output pav_pkg::pav_res_t      res
);
  import pav_pkg::*;

  localparam logic [4:0] C_IDLE = 5'd0;
  localparam logic [4:0] C_SQX  = 5'd1;
  localparam logic [4:0] C_SQY  = 5'd2;
  localparam logic [4:0] C_SQRT = 5'd3;
  localparam logic [4:0] C_DIVX = 5'd4;
  localparam logic [4:0] C_DIVY = 5'd5;
  localparam logic [4:0] C_MULP = 5'd6;
  localparam logic [4:0] C_MULF = 5'd7;
  localparam logic [4:0] C_MULM = 5'd8;
  localparam logic [4:0] C_MXL  = 5'd9;
  localparam logic [4:0] C_MXH  = 5'd10;
  localparam logic [4:0] C_MYL  = 5'd11;
  localparam logic [4:0] C_MYH  = 5'd12;
  localparam logic [4:0] C_V1Y  = 5'd13;
  localparam logic [4:0] C_DX   = 5'd14;
  localparam logic [4:0] C_DY   = 5'd15;
  localparam logic [4:0] C_FIN  = 5'd16;

  logic [4:0]       state;
  logic [CNT_W-1:0] cnt;
  pav_req_t         q;
  logic [30:0]      ax, ay;
  logic             negx, negy;
  logic [63:0]      sqn;
  logic [34:0]      rem;
  logic [31:0]      root, den;
  logic [24:0]      dlow, quo, ux, uy, f;
  logic [39:0]      m;
  logic [63:0]      tacc;
  logic [40:0]      tdx, tdy, dmx, dmy;
  logic signed [31:0] v1x, v1y, rx;

  // offset of the incoming particle
  logic signed [33:0] dx_s, dy_s;
  logic [33:0]        mx, my, mo;
  logic [30:0]        ax_s, ay_s;
  logic               flip;

  always_comb begin
    dx_s = {{2{req.target_x[15]}}, req.target_x, 16'd0} - {{2{req.pos_x[31]}}, req.pos_x};
    dy_s = {{2{req.pos_y[31]}}, req.pos_y} - {{2{req.target_y[15]}}, req.target_y, 16'd0};
    mx   = dx_s[33] ? 34'(-dx_s) : 34'(dx_s);
    my   = dy_s[33] ? 34'(-dy_s) : 34'(dy_s);
    mo   = mx | my;
    if (mo[32]) begin
      ax_s = mx[32:2];
      ay_s = my[32:2];
    end else if (mo[31]) begin
      ax_s = mx[31:1];
      ay_s = my[31:1];
    end else begin
      ax_s = mx[30:0];
      ay_s = my[30:0];
    end
    flip = req.accel[31] ^ req.repel;
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] v1x_mag, v1y_mag, acc_mag;

  always_comb begin
    v1x_mag = v1x[31] ? 32'(-v1x) : 32'(v1x);
    v1y_mag = v1y[31] ? 32'(-v1y) : 32'(v1y);
    acc_mag = q.accel[31] ? 32'(-q.accel) : 32'(q.accel);
    unique case (state)
      C_SQX:   begin mul_a = {1'b0, ax}; mul_b = {1'b0, ax}; end
      C_SQY:   begin mul_a = {1'b0, ay}; mul_b = {1'b0, ay}; end
      C_MULP:  begin mul_a = {9'd0, q.reduction_pct}; mul_b = {8'd0, q.step_time}; end
      C_MULF:  begin mul_a = {3'd0, tacc[46:18]}; mul_b = PCT_RECIP; end
      C_MULM:  begin mul_a = acc_mag; mul_b = {8'd0, q.step_time}; end
      C_MXL:   begin mul_a = m[31:0]; mul_b = {7'd0, ux}; end
      C_MXH:   begin mul_a = {24'd0, m[39:32]}; mul_b = {7'd0, ux}; end
      C_MYL:   begin mul_a = m[31:0]; mul_b = {7'd0, uy}; end
      C_MYH:   begin mul_a = {24'd0, m[39:32]}; mul_b = {7'd0, uy}; end
      C_DX:    begin mul_a = v1x_mag; mul_b = {7'd0, f}; end
      C_DY:    begin mul_a = v1y_mag; mul_b = {7'd0, f}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // shared trial subtractor for root and quotient digits
  logic [34:0] remsh_s, opa, opb;
  logic [32:0] remsh_d;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    remsh_s = {rem[32:0], sqn[63:62]};
    remsh_d = {rem[31:0], dlow[24]};
    if (state == C_SQRT) begin
      opa = remsh_s;
      opb = {1'b0, root, 2'b01};
    end else begin
      opa = {2'b0, remsh_d};
      opb = {3'b0, den};
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[35];
  end

  logic [65:0]        tsum;
  logic [40:0]        thi;
  logic signed [42:0] v1x_sum, v1y_sum, ry_sum, rx_sum;
  logic               sq_last, div_last;

  always_comb begin
    tsum     = {2'b0, tacc} + {mul_p[33:0], 32'd0};
    thi      = tsum[64:24];
    v1x_sum  = negx ? 43'(q.vel_x) - 43'({2'b0, tdx}) : 43'(q.vel_x) + 43'({2'b0, tdx});
    v1y_sum  = negy ? 43'(q.vel_y) - 43'({2'b0, tdy}) : 43'(q.vel_y) + 43'({2'b0, tdy});
    rx_sum   = v1x[31] ? 43'(v1x) + 43'({2'b0, dmx}) : 43'(v1x) - 43'({2'b0, dmx});
    ry_sum   = v1y[31] ? 43'(v1y) + 43'({2'b0, dmy}) : 43'(v1y) - 43'({2'b0, dmy});
    sq_last  = cnt == CNT_W'(SQRT_STEPS - 1);
    div_last = cnt == CNT_W'(DIV_STEPS - 1);
  end

  assign done      = state == C_FIN;
  assign res.vel_x = rx;
  assign res.vel_y = sat32(ry_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        C_IDLE: if (start) state <= C_SQX;
        C_SQX:  state <= C_SQY;
        C_SQY:  begin state <= C_SQRT; cnt <= '0; end
        C_SQRT: begin
          cnt <= sq_last ? '0 : cnt + 1'b1;
          if (sq_last) state <= C_DIVX;
        end
        C_DIVX, C_DIVY: begin
          cnt <= div_last ? '0 : cnt + 1'b1;
          if (div_last) begin
            priority case (state)
              C_DIVX:  state <= C_DIVY;
              default: state <= C_MULP;
            endcase
          end
        end
        C_MULP: state <= C_MULF;
        C_MULF: state <= C_MULM;
        C_MULM: state <= C_MXL;
        C_MXL:  state <= C_MXH;
        C_MXH:  state <= C_MYL;
        C_MYL:  state <= C_MYH;
        C_MYH:  state <= C_V1Y;
        C_V1Y:  state <= C_DX;
        C_DX:   state <= C_DY;
        C_DY:   state <= C_FIN;
        C_FIN:  state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      C_IDLE: begin
        if (start) begin
          q    <= req;
          ax   <= ax_s;
          ay   <= ay_s;
          negx <= dx_s[33] ^ flip;
          negy <= dy_s[33] ^ flip;
        end
      end
      C_SQX: sqn <= mul_p;
      C_SQY: begin
        sqn  <= sqn + mul_p;
        rem  <= '0;
        root <= '0;
      end
      C_SQRT: begin
        sqn  <= {sqn[61:0], 2'b00};
        root <= {root[30:0], ge};
        if (sq_last) begin
          den  <= {root[30:0], ge};
          rem  <= {5'd0, ax[30:1]};
          dlow <= {ax[0], 24'd0};
          quo  <= '0;
        end else begin
          rem  <= ge ? diff[34:0] : remsh_s;
        end
      end
      C_DIVX, C_DIVY: begin
        if (div_last) begin
          quo <= '0;
          priority case (state)
            C_DIVX: begin
              ux   <= {quo[23:0], ge};
              rem  <= {5'd0, ay[30:1]};
              dlow <= {ay[0], 24'd0};
            end
            default: uy <= {quo[23:0], ge};
          endcase
        end else begin
          dlow <= {dlow[23:0], 1'b0};
          quo  <= {quo[23:0], ge};
          rem  <= ge ? {3'd0, diff[31:0]} : {2'd0, remsh_d};
        end
      end
      C_MULP: tacc <= mul_p;
      C_MULF: f    <= mul_p[58:34];
      C_MULM: m    <= mul_p[55:16];
      C_MXL:  tacc <= mul_p;
      C_MXH:  tdx  <= thi;
      C_MYL: begin
        tacc <= mul_p;
        v1x  <= sat32(v1x_sum);
      end
      C_MYH:  tdy  <= thi;
      C_V1Y:  v1y  <= sat32(v1y_sum);
      C_DX:   dmx  <= mul_p[56:16];
      C_DY: begin
        dmy <= mul_p[56:16];
        rx  <= sat32(rx_sum);
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == C_IDLE)
    else $error("particle started while core busy");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == C_SQRT && sq_last) |=> (state == C_DIVX && den != '0))
    else $error("offset length is zero");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == C_DIVY && div_last) |=> (ux <= 25'h1000000 && uy <= 25'h1000000))
    else $error("unit component above one");

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result raised twice");

endmodule
`default_nettype wire
